[src/pas_pkg.sv]
`default_nettype none

package pas_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_TOTAL  = 1'b1;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_FEW_NODES    = 2'd1;
  localparam logic [1:0] STATUS_ZERO_WEIGHTS = 2'd2;

  typedef struct packed {
    logic       load;
    logic       ptr_clr;
    logic       sum_clr;
    logic       total_clr;
    logic       scan;
    logic       scan_c;
    logic       div_mul;
    logic       div_step;
    logic       div_wr;
    logic       adj;
    logic       emit_ld;
    logic       err_ld;
    logic [1:0] err_code;
  } pas_cmd_t;

  typedef struct packed {
    logic fire;
    logic nodes_short;
    logic scan_done;
    logic sum_zero;
    logic div_done;
    logic last_elem;
    logic total_eq;
    logic best_stuck;
    logic out_free;
  } pas_sts_t;

endpackage

`default_nettype wire

[src/pas_datapath.sv]
`default_nettype none

module pas_datapath #(
  parameter int MAX_STAGES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pas_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  input  wire logic [15:0]                   weight_i,
  input  wire pas_pkg::pas_cmd_t             cmd_i,
  output pas_pkg::pas_sts_t                  sts_o,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [3:0]                         stage_index_o,
  output logic [15:0]                        node_count_o,
  output logic [1:0]                         status_o,
  output logic                               last_o
);
  import pas_pkg::*;

  localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int NW = IW + 1;
  localparam int SW = 16 + IW;

  logic [4:0]    stage_count_q;
  logic [15:0]   node_total_q;
  logic [IW-1:0] load_idx_q;

  logic [15:0]   wmem [MAX_STAGES];
  logic [15:0]   cmem [MAX_STAGES];
  logic [15:0]   wrd_q;
  logic [15:0]   crd_q;

  logic [NW-1:0] ptr_q;
  logic          rv_q;
  logic [IW-1:0] ridx_q;
  logic [SW-1:0] sum_q;
  logic [SW-1:0] total_q;
  logic [15:0]   best_val_q;
  logic [IW-1:0] best_idx_q;

  logic [SW-1:0] rem_q;
  logic [15:0]   quo_q;
  logic [3:0]    step_q;

  logic          out_valid_q;
  logic [3:0]    stage_index_q;
  logic [15:0]   node_count_q;
  logic [1:0]    status_q;
  logic          last_q;

  logic [NW-1:0] n_eff;
  logic [IW-1:0] ptr_idx;
  logic          ptr_lt_n;
  logic [31:0]   prod;
  logic [SW:0]   trial;
  logic          ge;
  logic [15:0]   ceil_cnt;
  logic [SW-1:0] nodes_ext;
  logic          total_gt;
  logic [15:0]   adj_val;
  logic [NW+3:0] idx_ext;
  logic          out_free;

  always_comb begin
    if (stage_count_q == 5'd0) begin
      n_eff = NW'(1);
    end else if ({3'b000, stage_count_q} > 8'(MAX_STAGES)) begin
      n_eff = NW'(MAX_STAGES);
    end else begin
      n_eff = NW'(stage_count_q);
    end
  end

  assign ptr_idx   = ptr_q[IW-1:0];
  assign ptr_lt_n  = ptr_q < n_eff;
  assign prod      = wrd_q * node_total_q;
  assign trial     = {rem_q, quo_q[15]};
  assign ge        = trial >= {1'b0, sum_q};
  assign ceil_cnt  = quo_q + 16'(rem_q != '0);
  assign nodes_ext = SW'(node_total_q);
  assign total_gt  = total_q > nodes_ext;
  assign adj_val   = total_gt ? best_val_q - 16'd1 : best_val_q + 16'd1;
  assign idx_ext   = {4'b0000, ptr_q};
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.fire        = ({1'b0, load_idx_q} + NW'(1)) >= n_eff;
    sts_o.nodes_short = node_total_q < 16'(n_eff);
    sts_o.scan_done   = (ptr_q == n_eff) && !rv_q;
    sts_o.sum_zero    = sum_q == '0;
    sts_o.div_done    = step_q == 4'hF;
    sts_o.last_elem   = NW'(ptr_q + NW'(1)) == n_eff;
    sts_o.total_eq    = total_q == nodes_ext;
    sts_o.best_stuck  = total_gt ? (best_val_q == 16'h0000) : (best_val_q == 16'hFFFF);
    sts_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= 5'd1;
      node_total_q  <= 16'd1;
      load_idx_q    <= '0;
      ptr_q         <= '0;
      rv_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_STAGE_COUNT: stage_count_q <= cfg_data_i[4:0];
          CFG_NODE_TOTAL:  node_total_q  <= cfg_data_i;
          default:         node_total_q  <= node_total_q;
        endcase
      end
      if (cmd_i.load) begin
        load_idx_q <= sts_o.fire ? '0 : IW'(load_idx_q + IW'(1));
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if ((cmd_i.scan && ptr_lt_n) || cmd_i.div_wr || cmd_i.emit_ld) begin
        ptr_q <= NW'(ptr_q + NW'(1));
      end
      rv_q <= cmd_i.scan && ptr_lt_n && !cmd_i.ptr_clr;
      if (cmd_i.emit_ld || cmd_i.err_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wmem[load_idx_q] <= weight_i;
    end
    wrd_q <= wmem[ptr_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_wr) begin
      cmem[ptr_idx] <= ceil_cnt;
    end else if (cmd_i.adj) begin
      cmem[best_idx_q] <= adj_val;
    end
    crd_q <= cmem[ptr_idx];
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ptr_idx;
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.scan && !cmd_i.scan_c && rv_q) begin
      sum_q <= sum_q + SW'(wrd_q);
    end
    if (cmd_i.ptr_clr) begin
      best_val_q <= '0;
      best_idx_q <= '0;
    end else if (cmd_i.scan && cmd_i.scan_c && rv_q && (crd_q > best_val_q)) begin
      best_val_q <= crd_q;
      best_idx_q <= ridx_q;
    end
    if (cmd_i.total_clr) begin
      total_q <= '0;
    end else if (cmd_i.div_wr) begin
      total_q <= total_q + SW'(ceil_cnt);
    end else if (cmd_i.adj) begin
      total_q <= total_gt ? total_q - SW'(1) : total_q + SW'(1);
    end
    if (cmd_i.div_mul) begin
      rem_q  <= SW'(prod[31:16]);
      quo_q  <= prod[15:0];
      step_q <= 4'd0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? SW'(trial - {1'b0, sum_q}) : trial[SW-1:0];
      quo_q  <= {quo_q[14:0], ge};
      step_q <= step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      stage_index_q <= idx_ext[3:0];
      node_count_q  <= crd_q;
      status_q      <= STATUS_OK;
      last_q        <= sts_o.last_elem;
    end else if (cmd_i.err_ld) begin
      stage_index_q <= 4'd0;
      node_count_q  <= 16'd0;
      status_q      <= cmd_i.err_code;
      last_q        <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign stage_index_o = stage_index_q;
  assign node_count_o  = node_count_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

[src/pas_ctrl.sv]
`default_nettype none

module pas_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pas_pkg::pas_sts_t sts_i,
  output pas_pkg::pas_cmd_t      cmd_o
);
  import pas_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    CHECK,
    SUM,
    DIV_RD,
    DIV_MUL,
    DIV_STEP,
    DIV_WR,
    CORR,
    SCAN,
    ADJ,
    EMIT_RD,
    EMIT_LD,
    ERR
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] err_q, err_d;

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '0;
    cmd_o.err_code = err_q;
    unique case (state_q)
      IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.fire) state_d = CHECK;
      end
      CHECK: begin
        if (sts_i.nodes_short) begin
          err_d   = STATUS_FEW_NODES;
          state_d = ERR;
        end else begin
          cmd_o.ptr_clr = 1'b1;
          cmd_o.sum_clr = 1'b1;
          state_d       = SUM;
        end
      end
      SUM: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.sum_zero) begin
            err_d   = STATUS_ZERO_WEIGHTS;
            state_d = ERR;
          end else begin
            cmd_o.ptr_clr   = 1'b1;
            cmd_o.total_clr = 1'b1;
            state_d         = DIV_RD;
          end
        end
      end
      DIV_RD: state_d = DIV_MUL;
      DIV_MUL: begin
        cmd_o.div_mul = 1'b1;
        state_d       = DIV_STEP;
      end
      DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = DIV_WR;
      end
      DIV_WR: begin
        cmd_o.div_wr = 1'b1;
        state_d      = sts_i.last_elem ? CORR : DIV_RD;
      end
      CORR: begin
        cmd_o.ptr_clr = 1'b1;
        state_d       = sts_i.total_eq ? EMIT_RD : SCAN;
      end
      SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.scan_c = 1'b1;
        if (sts_i.scan_done) state_d = ADJ;
      end
      ADJ: begin
        if (sts_i.best_stuck) begin
          cmd_o.ptr_clr = 1'b1;
          state_d       = EMIT_RD;
        end else begin
          cmd_o.adj = 1'b1;
          state_d   = CORR;
        end
      end
      EMIT_RD: state_d = EMIT_LD;
      EMIT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d       = sts_i.last_elem ? IDLE : EMIT_RD;
        end
      end
      ERR: begin
        if (sts_i.out_free) begin
          cmd_o.err_ld = 1'b1;
          state_d      = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      err_q   <= STATUS_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  assign in_stall_o = state_q != IDLE;

endmodule

`default_nettype wire

[src/proportional_stage_allocator_unit.sv]
`default_nettype none

// Loads one weight per stage (one transfer per cycle while idle) and, on the
// last weight of a run, splits node_total over the stages as
// ceil(weight*nodes/sum), then trims the largest count (lowest index on ties)
// until the counts add up to node_total. One result per stage follows, last
// flagged; a run with too few nodes or all-zero weights gives a single error
// result instead. During a run the input is stalled. A run takes at most n-1
// trim steps for n stages; each stage's count comes from a multiply and the
// 16-step radix-2 divider, and each trim step scans the count memory through
// its single read port. The results can be held back by an output stall.
module proportional_stage_allocator_unit #(
  parameter int MAX_STAGES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pas_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [15:0]                   weight_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [3:0]                         stage_index_o,
  output logic [15:0]                        node_count_o,
  output logic [1:0]                         status_o,
  output logic                               last_o
);
  import pas_pkg::*;

  pas_cmd_t cmd;
  pas_sts_t sts;

  pas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pas_datapath #(
    .MAX_STAGES (MAX_STAGES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .weight_i      (weight_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .stage_index_o (stage_index_o),
    .node_count_o  (node_count_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
